@@ rtl/core/vfce_pkg.sv @@
// vfce_pkg: shared types, frame constants and the crc-16/modbus byte update
// used by the velocity frame encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vfce_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [7:0]  Hdr0     = 8'hA5;
  localparam logic [7:0]  Hdr1     = 8'h5A;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  typedef enum logic [IdxW-1:0] {
    IDX_HDR0   = 3'd0,
    IDX_HDR1   = 3'd1,
    IDX_LV_LO  = 3'd2,
    IDX_LV_HI  = 3'd3,
    IDX_AR_LO  = 3'd4,
    IDX_AR_HI  = 3'd5,
    IDX_CRC_LO = 3'd6,
    IDX_CRC_HI = 3'd7
  } byte_idx_t;

  typedef struct packed {
    logic [15:0] linear_velocity;
    logic [15:0] angular_rate;
  } cmd_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/vfce_in_stage.sv @@
// vfce_in_stage: input holding register for one command word
// depends on vfce_pkg
`timescale 1ns / 1ps
`default_nettype none

module vfce_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vfce_pkg::cmd_t in_cmd,
  output logic               hold_valid,
  output vfce_pkg::cmd_t     hold_cmd,
  input  wire logic          hold_take
);

  logic           valid_r, valid_nxt;
  vfce_pkg::cmd_t cmd_r;
  logic           load;

  assign in_ready = rst_n && (!valid_r || hold_take);
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (hold_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= in_cmd;
    end
  end

  assign hold_valid = valid_r;
  assign hold_cmd   = cmd_r;

endmodule

`default_nettype wire

@@ rtl/core/vfce_serializer.sv @@
// vfce_serializer: walks one command through the eight frame bytes, running
// the crc a byte at a time, into the output register; depends on vfce_pkg
`timescale 1ns / 1ps
`default_nettype none

module vfce_serializer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           hold_valid,
  input  wire vfce_pkg::cmd_t hold_cmd,
  output logic                hold_take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_frame_byte,
  output logic                out_last_byte
);

  logic                busy_r, busy_nxt;
  vfce_pkg::byte_idx_t idx_r, idx_nxt;
  vfce_pkg::cmd_t      cmd_r;
  logic [15:0]         crc_r, crc_nxt;
  logic                ov_r, ov_nxt;
  logic [7:0]          byte_r;
  logic                last_r;
  logic [7:0]          sel_byte;
  logic                emit;
  logic                at_end;

  always_comb begin
    unique case (idx_r)
      vfce_pkg::IDX_HDR0:   sel_byte = vfce_pkg::Hdr0;
      vfce_pkg::IDX_HDR1:   sel_byte = vfce_pkg::Hdr1;
      vfce_pkg::IDX_LV_LO:  sel_byte = cmd_r.linear_velocity[7:0];
      vfce_pkg::IDX_LV_HI:  sel_byte = cmd_r.linear_velocity[15:8];
      vfce_pkg::IDX_AR_LO:  sel_byte = cmd_r.angular_rate[7:0];
      vfce_pkg::IDX_AR_HI:  sel_byte = cmd_r.angular_rate[15:8];
      vfce_pkg::IDX_CRC_LO: sel_byte = crc_r[7:0];
      vfce_pkg::IDX_CRC_HI: sel_byte = crc_r[15:8];
      default:              sel_byte = 8'h00;
    endcase
  end

  assign emit      = busy_r && (!ov_r || out_ready);
  assign at_end    = (idx_r == vfce_pkg::IDX_CRC_HI);
  assign hold_take = hold_valid && (!busy_r || (emit && at_end));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    ov_nxt   = ov_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (emit) begin
      ov_nxt  = 1'b1;
      idx_nxt = vfce_pkg::byte_idx_t'(idx_r + 3'd1);
      // crc covers the header and payload only, then holds for the two crc words
      if (idx_r != vfce_pkg::IDX_CRC_LO && !at_end) begin
        crc_nxt = vfce_pkg::crc_byte(crc_r, sel_byte);
      end
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (hold_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = vfce_pkg::IDX_HDR0;
      crc_nxt  = vfce_pkg::CrcInit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= vfce_pkg::IDX_HDR0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (hold_take) begin
      cmd_r <= hold_cmd;
    end
    if (emit) begin
      byte_r <= sel_byte;
      last_r <= at_end;
    end
  end

  assign out_valid      = ov_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

`default_nettype wire

@@ rtl/core/velocity_frame_crc_encoder_top.sv @@
// velocity_frame_crc_encoder_top: motion command in, 8-byte crc-16/modbus
// frame out one word at a time; depends on vfce_pkg, vfce_in_stage, vfce_serializer
// commands pass the input register, then the serialiser's registered output word
// one output word per cycle from the serialiser unless out_ready stalls the output
// a new command is held in the input register while the previous frame drains
// reset: synchronous active-low rst_n clears all valid flags and the byte index
`timescale 1ns / 1ps
`default_nettype none

module velocity_frame_crc_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_linear_velocity,
  input  wire logic [15:0] in_angular_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);

  vfce_pkg::cmd_t in_cmd;
  vfce_pkg::cmd_t hold_cmd;
  logic           hold_valid;
  logic           hold_take;

  assign in_cmd.linear_velocity = in_linear_velocity;
  assign in_cmd.angular_rate    = in_angular_rate;

  vfce_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .hold_valid (hold_valid),
    .hold_cmd   (hold_cmd),
    .hold_take  (hold_take)
  );

  vfce_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold_valid     (hold_valid),
    .hold_cmd       (hold_cmd),
    .hold_take      (hold_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire

@@ rtl/core/vfce_checker.sv @@
// vfce_checker: port-level checks on frame order and command/word balance
// bound to velocity_frame_crc_encoder_top; depends on vfce_pkg
`timescale 1ns / 1ps
`default_nettype none

module vfce_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_last_byte
);

  logic [vfce_pkg::IdxW-1:0] pos_r;
  logic [2:0]                pend_r;
  logic                      in_acc;
  logic                      out_acc;
  logic                      frame_done;

  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign frame_done = out_acc && out_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pend_r <= '0;
    end else begin
      if (out_acc) begin
        pos_r <= pos_r + 3'd1;
      end
      pend_r <= pend_r + {2'b00, in_acc} - {2'b00, frame_done};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_last_byte))
    else $error("output word changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (pos_r == vfce_pkg::IDX_CRC_HI)))
    else $error("last marker out of place");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pos_r == vfce_pkg::IDX_HDR0 || pos_r == vfce_pkg::IDX_HDR1) |->
      out_frame_byte == ((pos_r == vfce_pkg::IDX_HDR0) ? vfce_pkg::Hdr0 : vfce_pkg::Hdr1))
    else $error("bad header word");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("output word with no command pending");

endmodule

bind velocity_frame_crc_encoder_top vfce_checker u_vfce_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte)
);

`default_nettype wire

@@ dv/tb_velocity_frame_crc_encoder_top.sv @@
// tb_velocity_frame_crc_encoder_top: self-checking bench for the velocity frame encoder,
// predicts each 8-word frame with its own crc-16/modbus and checks every output word
// depends on velocity_frame_crc_encoder_top only
`timescale 1ns / 1ps

module tb_velocity_frame_crc_encoder_top;

  localparam logic [7:0]  SYNC_A        = 8'hA5;
  localparam logic [7:0]  SYNC_B        = 8'h5A;
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
  localparam int          FRAME_WORDS   = 8;
  localparam int          CRC_SPAN      = 6;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          LONG_HOLD     = 64;
  localparam int          RANDOM_CMDS   = 196;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_linear_velocity;
  logic [15:0] in_angular_rate;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;

  frame_word_t expected_words[$];
  int          error_count  = 0;
  int          hold_request = 0;
  bit          rx_idle_en   = 0;
  bit          tx_idle_en   = 0;

  velocity_frame_crc_encoder_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_linear_velocity (in_linear_velocity),
    .in_angular_rate    (in_angular_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_last_byte      (out_last_byte)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                  input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REFL) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void predict_frame(input logic [15:0] lv, input logic [15:0] ar);
    logic [7:0]  frame [FRAME_WORDS];
    logic [15:0] crc;
    frame[0] = SYNC_A;
    frame[1] = SYNC_B;
    frame[2] = lv[7:0];
    frame[3] = lv[15:8];
    frame[4] = ar[7:0];
    frame[5] = ar[15:8];
    crc = CRC_SEED;
    for (int i = 0; i < CRC_SPAN; i++) begin
      crc = modbus_crc_step(crc, frame[i]);
    end
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    for (int i = 0; i < FRAME_WORDS; i++) begin
      expected_words.push_back('{value: frame[i], last: (i == FRAME_WORDS - 1)});
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_command(input logic [15:0] lv, input logic [15:0] ar);
    int gap;
    in_valid           <= 1'b1;
    in_linear_velocity <= lv;
    in_angular_rate    <= ar;
    do @(posedge clk); while (!in_ready);
    predict_frame(lv, ar);
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_frames();
    rx_idle_en = 0;
    tx_idle_en = 0;
    send_command(16'h0000, 16'h0000);
    send_command(16'hFFFF, 16'hFFFF);
    send_command(16'h7FFF, 16'h8000);
    send_command(16'h8000, 16'h7FFF);
    send_command(16'h0001, 16'hFFFF);
    send_command(16'hFFFF, 16'h0001);
    send_command(16'h00A5, 16'h5A00);
    send_command(16'hA55A, 16'h5AA5);
    send_command(16'h00FF, 16'hFF00);
    send_command(16'h5555, 16'hAAAA);
    send_command(16'hAAAA, 16'h5555);
    send_command(16'h03E8, 16'hFC18);
    wait_for_drain();
  endtask

  // receiver stalls long enough for the block to fill and hold off its input
  task automatic test_output_backpressure();
    rx_idle_en   = 0;
    tx_idle_en   = 0;
    hold_request = LONG_HOLD;
    repeat (10) send_command(pick_field(), pick_field());
    wait_for_drain();
  endtask

  task automatic test_sender_pause();
    rx_idle_en = 1;
    tx_idle_en = 1;
    repeat (4) send_command(pick_field(), pick_field());
    wait_for_drain();
    repeat (4) send_command(pick_field(), pick_field());
    wait_for_drain();
  endtask

  task automatic test_random_commands();
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 40 == 0) begin
        rx_idle_en = ((i / 40) % 4) inside {1, 3};
        tx_idle_en = ((i / 40) % 4) inside {2, 3};
      end
      send_command(pick_field(), pick_field());
    end
    wait_for_drain();
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_word
    frame_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: frame_byte %02h last_byte %0b", out_frame_byte, out_last_byte);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_frame_byte !== want.value) begin
          $error("frame_byte mismatch: expected %02h, got %02h", want.value, out_frame_byte);
          error_count++;
        end
        if (out_last_byte !== want.last) begin
          $error("last_byte mismatch: expected %0b, got %0b", want.last, out_last_byte);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_linear_velocity <= 16'h0000;
    in_angular_rate    <= 16'h0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_output_backpressure();
    test_sender_pause();
    test_random_commands();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/vfce_pkg.sv
rtl/core/vfce_in_stage.sv
rtl/core/vfce_serializer.sv
rtl/core/velocity_frame_crc_encoder_top.sv
rtl/core/vfce_checker.sv
dv/tb_velocity_frame_crc_encoder_top.sv
